// File: src/cle_pkg.sv
// Shared constants, command and status codes, and the text store request
// type for the cursor line-edit buffer. No dependencies.
package cle_pkg;

	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int CMD_W   = 4;
	localparam int CNT_W   = 8;
	localparam int STAT_W  = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SET       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd8;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// one write and one read per cycle on the text store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

endpackage

// File: src/cle_ifs.sv
// Valid/ready channel interfaces for the command and result words.
// Depends on cle_pkg.
interface cle_cmd_if import cle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_in;
	logic [CNT_W-1:0]  count;

	modport source (output valid, output command, output char_in, output count, input ready);
	modport sink (input valid, input command, input char_in, input count, output ready);
endinterface

interface cle_res_if import cle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic [LEN_W-1:0]  cursor_pos;
	logic [LEN_W-1:0]  text_length;
	logic              last;
	logic [STAT_W-1:0] status;

	modport source (output valid, output char_out, output cursor_pos, output text_length,
		output last, output status, input ready);
	modport sink (input valid, input char_out, input cursor_pos, input text_length,
		input last, input status, output ready);
endinterface

// File: src/cle_store.sv
// Text store: MAX_LEN x 8 memory, one write port, one read port with
// registered read data that holds when no read is issued. Depends on cle_pkg.
module cle_store import cle_pkg::*; (
	input  logic              clk,
	input  store_req_t        req,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// File: src/cursor_line_edit_buffer.sv
// Cursor line-edit buffer: top level with command decode, the copy sequencer
// and the result register. Depends on cle_pkg, cle_ifs and cle_store.
//
// Channels: request carries one command word (command, char_in, count);
// result carries result words (char_out, cursor_pos, text_length, last,
// status). A word moves on a rising edge with valid and ready both high.
// Every command gives one result word, except dump, which gives one word per
// held character, last set on the final one (or one status-2 word if empty).
// Clear, append, cursor moves and full-buffer drops go from idle straight to
// the result step. Insert, backspace and delete first copy the characters
// that move (those after the cursor for insert and backspace, those after
// the removed span for delete), one store entry per cycle through the text
// store's one read and one write port, and skip the copy when none move.
// Dump gives one character per cycle out of the store's read port while the
// receiver takes them. request.ready is high only while no command is
// in work; the result register lets the next command be taken while a
// word waits. A stalled receiver holds the sequencer in its result or dump
// step, which resumes where it stopped; a running copy finishes first.
// Reset clears length and cursor and empties the result register; the store
// contents are not cleared, as only entries below the length are ever read.
module cursor_line_edit_buffer import cle_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	cle_cmd_if.sink   request,
	cle_res_if.source result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_COPY = 3'd1;
	localparam logic [2:0] S_RES  = 3'd2;
	localparam logic [2:0] S_DUMP = 3'd3;

	logic [2:0]        state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cur_q, cur_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic              out_valid_q, out_valid_d;
	logic              put_pend_q, put_pend_d;
	logic              wv_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [ADDR_W-1:0] rd_q, rd_d;
	logic [ADDR_W-1:0] wr_q, wr_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [ADDR_W-1:0] put_addr_q, put_addr_d;
	logic              back_q, back_d;
	logic [CHAR_W-1:0] ch_q, ch_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic [CHAR_W-1:0] o_char_q, o_char_d;
	logic [LEN_W-1:0]  o_cur_q, o_cur_d;
	logic [LEN_W-1:0]  o_len_q, o_len_d;
	logic              o_last_q, o_last_d;
	logic [STAT_W-1:0] o_st_q, o_st_d;

	logic              acc, out_free, full, dump_last;
	logic [LEN_W-1:0]  room, bs_n, dl_n;
	logic [CHAR_W-1:0] rdata;
	store_req_t        sreq;

	assign acc       = request.valid && request.ready;
	assign out_free  = !out_valid_q || result.ready;
	assign full      = (len_q == LEN_W'(MAX_LEN));
	assign room      = len_q - cur_q;
	assign bs_n      = (request.count > CNT_W'(cur_q)) ? cur_q : LEN_W'(request.count);
	assign dl_n      = (request.count > CNT_W'(room)) ? room : LEN_W'(request.count);
	assign dump_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	assign request.ready      = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.char_out    = o_char_q;
	assign result.cursor_pos  = o_cur_q;
	assign result.text_length = o_len_q;
	assign result.last        = o_last_q;
	assign result.status      = o_st_q;

	cle_store u_store (
		.clk   (clk),
		.req   (sreq),
		.rdata (rdata)
	);

	// store port: copy writes, deferred insert char, append
	always_comb begin
		sreq = '0;
		priority if (wv_s1) begin
			sreq.we    = 1'b1;
			sreq.waddr = wa_s1;
			sreq.wdata = rdata;
		end else if (state_q == S_RES && put_pend_q) begin
			sreq.we    = 1'b1;
			sreq.waddr = put_addr_q;
			sreq.wdata = ch_q;
		end else if (acc && request.command == CMD_APPEND && !full) begin
			sreq.we    = 1'b1;
			sreq.waddr = ADDR_W'(len_q);
			sreq.wdata = request.char_in;
		end else begin
			sreq.we = 1'b0;
		end

		priority if (state_q == S_COPY && rem_q != '0) begin
			sreq.re    = 1'b1;
			sreq.raddr = rd_q;
		end else if (state_q == S_DUMP && out_free && !dump_last) begin
			sreq.re    = 1'b1;
			sreq.raddr = idx_q + ADDR_W'(1);
		end else if (acc && request.command == CMD_DUMP) begin
			sreq.re    = 1'b1;
			sreq.raddr = '0;
		end else begin
			sreq.re = 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		cur_d       = cur_q;
		rem_d       = rem_q;
		out_valid_d = out_valid_q && !result.ready;
		put_pend_d  = put_pend_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		idx_d       = idx_q;
		put_addr_d  = put_addr_q;
		back_d      = back_q;
		ch_d        = ch_q;
		st_d        = st_q;
		o_char_d    = o_char_q;
		o_cur_d     = o_cur_q;
		o_len_d     = o_len_q;
		o_last_d    = o_last_q;
		o_st_d      = o_st_q;

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					st_d       = STAT_OK;
					put_pend_d = 1'b0;
					state_d    = S_RES;
					unique case (request.command)
						CMD_CLEAR: begin
							len_d = '0;
							cur_d = '0;
						end
						CMD_APPEND: begin
							if (full) st_d = STAT_FULL;
							else len_d = len_q + LEN_W'(1);
						end
						CMD_SET: begin
							cur_d = (request.count > CNT_W'(len_q)) ? len_q
								: LEN_W'(request.count);
						end
						CMD_LEFT: begin
							cur_d = (request.count > CNT_W'(cur_q)) ? '0
								: cur_q - LEN_W'(request.count);
						end
						CMD_RIGHT: begin
							cur_d = (request.count > CNT_W'(room)) ? len_q
								: cur_q + LEN_W'(request.count);
						end
						CMD_INSERT: begin
							if (full) begin
								st_d = STAT_FULL;
							end else begin
								len_d      = len_q + LEN_W'(1);
								cur_d      = cur_q + LEN_W'(1);
								put_pend_d = 1'b1;
								put_addr_d = ADDR_W'(cur_q);
								ch_d       = request.char_in;
								if (room != '0) begin
									rd_d    = ADDR_W'(len_q - LEN_W'(1));
									wr_d    = ADDR_W'(len_q);
									rem_d   = room;
									back_d  = 1'b1;
									state_d = S_COPY;
								end
							end
						end
						CMD_BACKSPACE: begin
							len_d = len_q - bs_n;
							cur_d = cur_q - bs_n;
							if (bs_n != '0 && room != '0) begin
								rd_d    = ADDR_W'(cur_q);
								wr_d    = ADDR_W'(cur_q - bs_n);
								rem_d   = room;
								back_d  = 1'b0;
								state_d = S_COPY;
							end
						end
						CMD_DELETE: begin
							len_d = len_q - dl_n;
							if (dl_n != '0 && room != dl_n) begin
								rd_d    = ADDR_W'(cur_q + dl_n);
								wr_d    = ADDR_W'(cur_q);
								rem_d   = room - dl_n;
								back_d  = 1'b0;
								state_d = S_COPY;
							end
						end
						CMD_DUMP: begin
							if (len_q == '0) begin
								st_d = STAT_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			S_COPY: begin
				// each write lands in the cycle after its read; the last write drains on exit
				if (rem_q != '0) begin
					rem_d = rem_q - LEN_W'(1);
					rd_d  = back_q ? rd_q - ADDR_W'(1) : rd_q + ADDR_W'(1);
					wr_d  = back_q ? wr_q - ADDR_W'(1) : wr_q + ADDR_W'(1);
				end else begin
					state_d = S_RES;
				end
			end
			S_RES: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					o_char_d    = '0;
					o_cur_d     = cur_q;
					o_len_d     = len_q;
					o_last_d    = 1'b1;
					o_st_d      = st_q;
					put_pend_d  = 1'b0;
					state_d     = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					o_char_d    = rdata;
					o_cur_d     = cur_q;
					o_len_d     = len_q;
					o_last_d    = dump_last;
					o_st_d      = STAT_OK;
					if (dump_last) state_d = S_IDLE;
					else idx_d = idx_q + ADDR_W'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			put_pend_q  <= 1'b0;
			wv_s1       <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			cur_q       <= cur_d;
			rem_q       <= rem_d;
			out_valid_q <= out_valid_d;
			put_pend_q  <= put_pend_d;
			wv_s1       <= (state_q == S_COPY) && (rem_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		wa_s1      <= wr_q;
		rd_q       <= rd_d;
		wr_q       <= wr_d;
		idx_q      <= idx_d;
		put_addr_q <= put_addr_d;
		back_q     <= back_d;
		ch_q       <= ch_d;
		st_q       <= st_d;
		o_char_q   <= o_char_d;
		o_cur_q    <= o_cur_d;
		o_len_q    <= o_len_d;
		o_last_q   <= o_last_d;
		o_st_q     <= o_st_d;
	end

	a_cur_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond text length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("text length beyond capacity");

	a_copy_write_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> (state_q == S_COPY))
		else $error("copy write outside copy sequence");

	a_dump_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (LEN_W'(idx_q) < len_q))
		else $error("dump index past text end");

endmodule
